@@ design/rvdec_pkg.sv @@
package rvdec_pkg;

    localparam logic [6:0] OPC_U_MASK = 7'b0010100;
    localparam logic [6:0] OPC_JAL    = 7'b1101111;
    localparam logic [6:0] OPC_OP     = 7'b0110011;
    localparam logic [6:0] OPC_LOAD   = 7'b0000011;
    localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
    localparam logic [6:0] OPC_SYSTEM = 7'b1110011;
    localparam logic [6:0] OPC_JALR   = 7'b1100111;
    localparam logic [6:0] OPC_STORE  = 7'b0100011;
    localparam logic [6:0] OPC_BRANCH = 7'b1100011;

    localparam logic [2:0] FMT_NONE = 3'd0;
    localparam logic [2:0] FMT_U    = 3'd1;
    localparam logic [2:0] FMT_J    = 3'd2;
    localparam logic [2:0] FMT_R    = 3'd3;
    localparam logic [2:0] FMT_I    = 3'd4;
    localparam logic [2:0] FMT_S    = 3'd5;
    localparam logic [2:0] FMT_B    = 3'd6;

    localparam logic [1:0] VAR_ZERO  = 2'd0;
    localparam logic [1:0] VAR_OTHER = 2'd1;
    localparam logic [1:0] VAR_ONE   = 2'd2;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 56;

    typedef struct packed {
        logic        ends_block;
        logic [1:0]  variant_sel;
        logic [7:0]  cmd_index;
        logic [19:0] immediate;
        logic [4:0]  src_reg_b;
        logic [4:0]  src_reg_a;
        logic [4:0]  dest_reg;
        logic [2:0]  format_class;
    } dec_result_t;

endpackage

@@ design/rv32im_instruction_decoder_unit.sv @@
// An accepted input word passes through an input register and a result register to the master side.
// Throughput: one word per cycle unless m_tready stalls; an input register feeds the decode logic
// and a result register holds the decoded word until it is taken.
// Reset: rst_n asynchronous, active low; clears both stage valid flags, payload is not reset.
module rv32im_instruction_decoder_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [rvdec_pkg::IN_DATA_W-1:0]   s_tdata,  // instr_word[31:0]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [rvdec_pkg::OUT_DATA_W-1:0]  m_tdata   // format_class[2:0], dest_reg[7:3],
                                                        // src_reg_a[12:8], src_reg_b[17:13],
                                                        // immediate[37:18], cmd_index[45:38],
                                                        // variant_sel[47:46], ends_block[48],
                                                        // zero[55:49]
);
    import rvdec_pkg::*;

    logic        in_valid_reg;
    logic [31:0] in_word_reg;
    logic        out_valid_reg;
    dec_result_t out_result_reg;
    dec_result_t dec_result;
    logic        out_load;

    assign out_load = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || out_load;

    rvdec_decode u_decode
    (
        .instr  (in_word_reg),
        .result (dec_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (out_load)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_word_reg <= s_tdata;
        end
        if (out_load && in_valid_reg)
        begin
            out_result_reg <= dec_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - $bits(dec_result_t)){1'b0}}, out_result_reg};

endmodule

@@ design/rvdec_decode.sv @@
module rvdec_decode
(
    input  logic [31:0]          instr,
    output rvdec_pkg::dec_result_t result
);
    import rvdec_pkg::*;

    logic [6:0] opc;
    logic [2:0] f3;
    logic [6:0] f7;
    logic [2:0] use_f3;
    logic [6:0] use_f7;

    assign opc = instr[6:0];
    assign f3  = instr[14:12];
    assign f7  = instr[31:25];

    always_comb
    begin
        result.format_class = FMT_NONE;
        result.dest_reg     = '0;
        result.src_reg_a    = '0;
        result.src_reg_b    = '0;
        result.immediate    = '0;
        result.ends_block   = 1'b0;
        use_f3              = '0;
        use_f7              = '0;
        if ((opc & OPC_U_MASK) == OPC_U_MASK)
        begin
            result.format_class = FMT_U;
            result.dest_reg     = instr[11:7];
            result.immediate    = instr[31:12];
        end
        else
        begin
            unique case (opc) inside
                OPC_JAL:
                begin
                    result.format_class = FMT_J;
                    result.dest_reg     = instr[11:7];
                    result.immediate    = {instr[31], instr[19:12], instr[20], instr[30:21]};
                    result.ends_block   = 1'b1;
                end
                OPC_OP:
                begin
                    result.format_class = FMT_R;
                    result.dest_reg     = instr[11:7];
                    result.src_reg_a    = instr[19:15];
                    result.src_reg_b    = instr[24:20];
                    use_f3              = f3;
                    use_f7              = f7;
                end
                OPC_LOAD, OPC_OPIMM, OPC_SYSTEM, OPC_JALR:
                begin
                    result.format_class = FMT_I;
                    result.dest_reg     = instr[11:7];
                    result.src_reg_a    = instr[19:15];
                    result.immediate    = {{8{instr[31]}}, instr[31:20]};
                    use_f3              = f3;
                    result.ends_block   = (opc == OPC_JALR) ||
                                          ((opc == OPC_SYSTEM) && (f3 == 3'd0));
                end
                OPC_STORE:
                begin
                    result.format_class = FMT_S;
                    result.src_reg_a    = instr[19:15];
                    result.src_reg_b    = instr[24:20];
                    result.immediate    = {{8{instr[31]}}, instr[31:25], instr[11:7]};
                    use_f3              = f3;
                end
                OPC_BRANCH:
                begin
                    result.format_class = FMT_B;
                    result.src_reg_a    = instr[19:15];
                    result.src_reg_b    = instr[24:20];
                    result.immediate    = {{8{instr[31]}}, instr[31], instr[7],
                                           instr[30:25], instr[11:8]};
                    use_f3              = f3;
                    result.ends_block   = 1'b1;
                end
                default:
                begin
                    result.format_class = FMT_NONE;
                end
            endcase
        end
        result.cmd_index = {use_f3, opc[6:2]};
        if (use_f7 == 7'd0)
        begin
            result.variant_sel = VAR_ZERO;
        end
        else if (use_f7 == 7'd1)
        begin
            result.variant_sel = VAR_ONE;
        end
        else
        begin
            result.variant_sel = VAR_OTHER;
        end
    end

endmodule
